[hw/rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the strobe and enable pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    localparam int unsigned REG_W      = 8;
    localparam int unsigned CNT_W      = 9;
    localparam int unsigned SEND_W     = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [REG_W-1:0]  ENDLESS_LIMIT = 8'd251;
    localparam logic [SEND_W-1:0] SEND_EVERY    = 5'd30;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_STEPS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STROBE_END_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_START_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_LENGTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LIMIT      = 3'd6;

    // Register values after reset.
    localparam logic [REG_W-1:0] RST_PRESCALE_TICKS    = 8'h30;
    localparam logic [REG_W-1:0] RST_PERIOD_STEPS      = 8'hF8;
    localparam logic [REG_W-1:0] RST_STROBE_END_STEP   = 8'h01;
    localparam logic [REG_W-1:0] RST_ENABLE_START_STEP = 8'h0A;
    localparam logic [REG_W-1:0] RST_ENABLE_LENGTH     = 8'h04;
    localparam logic [REG_W-1:0] RST_SAMPLE_INTERVAL   = 8'hFA;
    localparam logic [REG_W-1:0] RST_PERIOD_LIMIT      = ENDLESS_LIMIT;

    typedef struct packed {
        logic [REG_W-1:0] prescale_ticks;
        logic [REG_W-1:0] period_steps;
        logic [REG_W-1:0] strobe_end_step;
        logic [REG_W-1:0] enable_start_step;
        logic [REG_W-1:0] enable_length;
        logic [REG_W-1:0] sample_interval;
        logic [REG_W-1:0] period_limit;
    } sps_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  prescale_count;
        logic [CNT_W-1:0]  step_count;
        logic [REG_W-1:0]  periods_done;
        logic [CNT_W-1:0]  sample_count;
        logic [SEND_W-1:0] send_count;
        logic              strobe_level;
        logic              enable_level;
    } sps_state_t;

    typedef struct packed {
        logic running;
        logic send_now;
        logic sample_now;
        logic enable;
        logic strobe_res;
    } sps_result_t;

endpackage

`default_nettype wire

[hw/rtl/sps_tick_logic.sv]
// ----------------------------------------------------------------------------
// sps_tick_logic
// Next-state and result logic for one tick of the pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_tick_logic import sps_pkg::*; (
    input  wire sps_cfg_t    cfg,
    input  wire sps_state_t  state_cur,
    input  wire logic        restart,
    output sps_state_t       state_next,
    output sps_result_t      result
);

    logic [CNT_W-1:0] enable_end;

    // The end step is formed at full width so that it never wraps.
    assign enable_end = {1'b0, cfg.enable_start_step} + {1'b0, cfg.enable_length};

    always_comb begin
        sps_state_t s;
        sps_result_t r;
        s = state_cur;
        r = '0;

        if (restart) begin
            s.prescale_count = '0;
            s.step_count     = '0;
            s.periods_done   = '0;
            s.sample_count   = '0;
            s.strobe_level   = 1'b0;
            s.enable_level   = 1'b0;
        end

        if (s.periods_done < cfg.period_limit) begin
            r.running = 1'b1;
            if (s.sample_count >= {1'b0, cfg.sample_interval}) begin
                s.sample_count = '0;
                r.sample_now   = 1'b1;
                if (s.send_count >= SEND_EVERY) begin
                    s.send_count = '0;
                    r.send_now   = 1'b1;
                end
                s.send_count = s.send_count + 1'b1;
            end
            s.sample_count = s.sample_count + 1'b1;

            if (s.prescale_count >= {1'b0, cfg.prescale_ticks}) begin
                s.prescale_count = '0;
                // A prescaler step adds a second count to the sample counter.
                s.sample_count   = s.sample_count + 1'b1;
                if (s.step_count >= {1'b0, cfg.period_steps}) begin
                    s.step_count   = '0;
                    s.strobe_level = 1'b1;
                    s.enable_level = 1'b0;
                    if (cfg.period_limit != ENDLESS_LIMIT) begin
                        s.periods_done = s.periods_done + 1'b1;
                    end
                end
                // Later matches override earlier ones on the same step.
                if (s.step_count == {1'b0, cfg.strobe_end_step}) begin
                    s.strobe_level = 1'b0;
                end
                if (s.step_count == {1'b0, cfg.enable_start_step}) begin
                    s.enable_level = 1'b1;
                end
                if (s.step_count == enable_end) begin
                    s.enable_level = 1'b0;
                end
                s.step_count = s.step_count + 1'b1;
            end
            s.prescale_count = s.prescale_count + 1'b1;
        end

        r.strobe_res = s.strobe_level;
        r.enable     = s.enable_level;

        state_next = s;
        result     = r;
    end

endmodule

`default_nettype wire

[hw/rtl/strobe_and_enable_pulse_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// strobe_and_enable_pulse_sequencer_unit
// Tick-driven strobe, enable, sample and send pulse sequencer.
// ----------------------------------------------------------------------------
// Each input word is one tick; bit 0 of s_tdata is a restart that clears the run
// counters other than the send counter, and both output levels, before the tick
// is processed. Every accepted tick gives exactly one result word, registered and
// valid from the next cycle, and a new tick is taken every clock cycle as long as
// the result register is empty or is being emptied in the same cycle. All counter
// updates sit in one combinational step between the state registers and the
// result register. Configuration registers may be rewritten at any time when no
// tick is in flight; the counters keep their values across such writes.
`default_nettype none

module strobe_and_enable_pulse_sequencer_unit import sps_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [REG_W-1:0]      cfg_data,
    // Tick input.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    // Result output.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata    // [0] strobe_res, [1] enable,
                                                  // [2] sample_now, [3] send_now,
                                                  // [4] running, [7:5] zero
);

    sps_cfg_t    cfg_reg;
    sps_state_t  state_reg;
    sps_state_t  state_next;
    sps_result_t result_next;
    sps_result_t result_reg;
    logic        out_valid_reg;
    logic        accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    sps_tick_logic u_tick (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .restart    (s_tdata[0]),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prescale_ticks    <= RST_PRESCALE_TICKS;
            cfg_reg.period_steps      <= RST_PERIOD_STEPS;
            cfg_reg.strobe_end_step   <= RST_STROBE_END_STEP;
            cfg_reg.enable_start_step <= RST_ENABLE_START_STEP;
            cfg_reg.enable_length     <= RST_ENABLE_LENGTH;
            cfg_reg.sample_interval   <= RST_SAMPLE_INTERVAL;
            cfg_reg.period_limit      <= RST_PERIOD_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PRESCALE_TICKS:    cfg_reg.prescale_ticks    <= cfg_data;
                REG_PERIOD_STEPS:      cfg_reg.period_steps      <= cfg_data;
                REG_STROBE_END_STEP:   cfg_reg.strobe_end_step   <= cfg_data;
                REG_ENABLE_START_STEP: cfg_reg.enable_start_step <= cfg_data;
                REG_ENABLE_LENGTH:     cfg_reg.enable_length     <= cfg_data;
                REG_SAMPLE_INTERVAL:   cfg_reg.sample_interval   <= cfg_data;
                REG_PERIOD_LIMIT:      cfg_reg.period_limit      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 5){1'b0}}, result_reg.running, result_reg.send_now,
                       result_reg.sample_now, result_reg.enable, result_reg.strobe_res};

endmodule

`default_nettype wire
